/* hw/rtl/pdft_pkg.sv */
// Shared types and constants for the PPS-disciplined frame timer.
package pdft_pkg;

    localparam int RING_AW    = 4;
    localparam int RING_DEPTH = 2 ** RING_AW;

    localparam logic [RING_AW-1:0] HEAD_STEP = RING_AW'(1);

    localparam logic [7:0] PPS_WIDTH_RESET = 8'd10;

    localparam logic [1:0] KIND_PPS  = 2'd0;
    localparam logic [1:0] KIND_SLOW = 2'd1;
    localparam logic [1:0] KIND_FAST = 2'd2;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_GLOBAL_ENABLE  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_START_TIME     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_STOP_TIME      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BURST_PULSES   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PPS_WIDTH      = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_INITIAL_PERIOD = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] capture_count;
        logic [31:0] gps_time;
    } event_t;

    typedef struct packed {
        logic        frames_running;
        logic        pps_level;
        logic        frame_level;
        logic        led_level;
        logic [31:0] period;
        logic [31:0] frame_count;
        logic [31:0] pulse_count;
    } result_t;

endpackage

/* hw/rtl/pdft_if.sv */
// Valid/ready channel interfaces for events and results.
interface pdft_event_if;
    logic              valid;
    logic              ready;
    pdft_pkg::event_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdft_result_if;
    logic              valid;
    logic              ready;
    pdft_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pps_disciplined_frame_timer.sv */
// Top level of the PPS-disciplined frame timer.
// The event is registered in the s1 stage and moves to the result register once that
// register is empty or being taken, so a stalled result holds the next event back.
// Throughput: one event per cycle while results are taken; the ring memory is read in the
// accept cycle and written back when the event executes from the s1 stage.
// Reset: control state returns to its reset values (start and stop re-armed), PPS width
// returns to ten slow ticks, and the per-entry ring flags clear at once so every ring entry reads as zero.
module pps_disciplined_frame_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    pdft_event_if.sink                          event_ch,
    pdft_result_if.source                       result_ch,
    input  logic                                cfg_we,
    input  logic [pdft_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [pdft_pkg::CFG_DW-1:0]         cfg_data
);

    logic [31:0] ring_mem [pdft_pkg::RING_DEPTH];

    logic                              s1_valid_reg;
    pdft_pkg::event_t                  s1_item_reg;
    logic [pdft_pkg::RING_AW-1:0]      s1_addr_reg;
    logic [31:0]                       s1_old_reg;
    logic                              s1_old_ok_reg;

    logic                              out_valid_reg, out_valid_next;
    pdft_pkg::result_t                 out_data_reg;

    logic [pdft_pkg::RING_AW-1:0]      issue_head_reg;
    logic [pdft_pkg::RING_DEPTH-1:0]   ring_ok_reg, ring_ok_next;

    logic        global_enable_reg, global_enable_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] stop_time_reg, stop_time_next;
    logic [7:0]  pps_width_reg, pps_width_next;
    logic        start_armed_reg, start_armed_next;
    logic        stop_armed_reg, stop_armed_next;
    logic        window_en_reg, window_en_next;
    logic [15:0] burst_left_reg, burst_left_next;
    logic        running_reg, running_next;
    logic [7:0]  pps_hold_reg, pps_hold_next;
    logic        pps_out_reg, pps_out_next;
    logic        seen_pulse_reg, seen_pulse_next;
    logic [31:0] last_capture_reg, last_capture_next;
    logic [31:0] ring_total_reg, ring_total_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] frames_reg, frames_next;
    logic [31:0] pulses_reg, pulses_next;

    logic        advance;
    logic        accept;
    logic        exec_pps;
    logic [31:0] time_next;
    logic [31:0] delta;
    logic [31:0] old_entry;

    assign advance        = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign event_ch.ready = !s1_valid_reg || advance;
    assign accept         = event_ch.valid && event_ch.ready;
    assign exec_pps       = advance && (s1_item_reg.kind == pdft_pkg::KIND_PPS);

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    assign time_next = s1_item_reg.gps_time + 32'd1;
    assign delta     = s1_item_reg.capture_count - last_capture_reg;
    assign old_entry = s1_old_ok_reg ? s1_old_reg : 32'd0;

    always_comb
    begin
        global_enable_next = global_enable_reg;
        start_time_next    = start_time_reg;
        stop_time_next     = stop_time_reg;
        pps_width_next     = pps_width_reg;
        start_armed_next   = start_armed_reg;
        stop_armed_next    = stop_armed_reg;
        window_en_next     = window_en_reg;
        burst_left_next    = burst_left_reg;
        running_next       = running_reg;
        pps_hold_next      = pps_hold_reg;
        pps_out_next       = pps_out_reg;
        seen_pulse_next    = seen_pulse_reg;
        last_capture_next  = last_capture_reg;
        ring_total_next    = ring_total_reg;
        period_next        = period_reg;
        tick_count_next    = tick_count_reg;
        frames_next        = frames_reg;
        pulses_next        = pulses_reg;
        ring_ok_next       = ring_ok_reg;

        if (advance)
        begin
            case (s1_item_reg.kind)
                pdft_pkg::KIND_PPS:
                begin
                    if (start_armed_reg && start_time_reg != 32'd0
                        && time_next >= start_time_reg)
                    begin
                        window_en_next   = 1'b1;
                        start_armed_next = 1'b0;
                    end
                    if (stop_armed_reg && stop_time_reg != 32'd0
                        && time_next >= stop_time_reg)
                    begin
                        window_en_next  = 1'b0;
                        stop_armed_next = 1'b0;
                    end
                    if (global_enable_reg || window_en_next || burst_left_reg != 16'd0)
                    begin
                        if (burst_left_reg != 16'd0)
                        begin
                            burst_left_next = burst_left_reg - 16'd1;
                        end
                        running_next = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b0;
                    end
                    tick_count_next = 32'd0;
                    pps_out_next    = 1'b1;
                    if (pps_hold_reg == 8'd0)
                    begin
                        pps_hold_next = pps_width_reg;
                    end
                    seen_pulse_next   = 1'b1;
                    last_capture_next = s1_item_reg.capture_count;
                    ring_total_next   = ring_total_reg - old_entry + delta;
                    ring_ok_next[s1_addr_reg] = 1'b1;
                    if (s1_addr_reg == {pdft_pkg::RING_AW{1'b1}})
                    begin
                        period_next = ring_total_next >> pdft_pkg::RING_AW;
                    end
                    pulses_next = pulses_reg + 32'd1;
                end
                pdft_pkg::KIND_SLOW:
                begin
                    if (pps_hold_reg != 8'd0)
                    begin
                        pps_hold_next = pps_hold_reg - 8'd1;
                        if (pps_hold_reg == 8'd1)
                        begin
                            pps_out_next = 1'b0;
                        end
                    end
                end
                pdft_pkg::KIND_FAST:
                begin
                    if (running_reg)
                    begin
                        if (tick_count_reg >= period_reg)
                        begin
                            tick_count_next = 32'd0;
                            if (seen_pulse_reg)
                            begin
                                frames_next = frames_reg + 32'd1;
                            end
                        end
                        else
                        begin
                            tick_count_next = tick_count_reg + 32'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                pdft_pkg::CFG_GLOBAL_ENABLE:
                begin
                    global_enable_next = cfg_data[0];
                end
                pdft_pkg::CFG_START_TIME:
                begin
                    start_time_next  = cfg_data;
                    start_armed_next = 1'b1;
                end
                pdft_pkg::CFG_STOP_TIME:
                begin
                    stop_time_next  = cfg_data;
                    stop_armed_next = 1'b1;
                end
                pdft_pkg::CFG_BURST_PULSES:
                begin
                    burst_left_next = cfg_data[15:0];
                end
                pdft_pkg::CFG_PPS_WIDTH:
                begin
                    pps_width_next = cfg_data[7:0];
                end
                pdft_pkg::CFG_INITIAL_PERIOD:
                begin
                    period_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            issue_head_reg    <= '0;
            ring_ok_reg       <= '0;
            global_enable_reg <= 1'b0;
            start_time_reg    <= 32'd0;
            stop_time_reg     <= 32'd0;
            pps_width_reg     <= pdft_pkg::PPS_WIDTH_RESET;
            start_armed_reg   <= 1'b1;
            stop_armed_reg    <= 1'b1;
            window_en_reg     <= 1'b0;
            burst_left_reg    <= 16'd0;
            running_reg       <= 1'b0;
            pps_hold_reg      <= 8'd0;
            pps_out_reg       <= 1'b0;
            seen_pulse_reg    <= 1'b0;
            last_capture_reg  <= 32'd0;
            ring_total_reg    <= 32'd0;
            period_reg        <= 32'd0;
            tick_count_reg    <= 32'd0;
            frames_reg        <= 32'd0;
            pulses_reg        <= 32'd0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (accept && event_ch.data.kind == pdft_pkg::KIND_PPS)
            begin
                issue_head_reg <= issue_head_reg + pdft_pkg::HEAD_STEP;
            end
            out_valid_reg     <= out_valid_next;
            ring_ok_reg       <= ring_ok_next;
            global_enable_reg <= global_enable_next;
            start_time_reg    <= start_time_next;
            stop_time_reg     <= stop_time_next;
            pps_width_reg     <= pps_width_next;
            start_armed_reg   <= start_armed_next;
            stop_armed_reg    <= stop_armed_next;
            window_en_reg     <= window_en_next;
            burst_left_reg    <= burst_left_next;
            running_reg       <= running_next;
            pps_hold_reg      <= pps_hold_next;
            pps_out_reg       <= pps_out_next;
            seen_pulse_reg    <= seen_pulse_next;
            last_capture_reg  <= last_capture_next;
            ring_total_reg    <= ring_total_next;
            period_reg        <= period_next;
            tick_count_reg    <= tick_count_next;
            frames_reg        <= frames_next;
            pulses_reg        <= pulses_next;
        end
    end

    // Payload stage, ring memory port and result data register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= event_ch.data;
            s1_addr_reg   <= issue_head_reg;
            s1_old_reg    <= ring_mem[issue_head_reg];
            s1_old_ok_reg <= ring_ok_reg[issue_head_reg];
        end
        if (exec_pps)
        begin
            ring_mem[s1_addr_reg] <= delta;
        end
        if (advance)
        begin
            out_data_reg.frames_running <= running_next;
            out_data_reg.pps_level      <= pps_out_next;
            out_data_reg.frame_level    <= frames_next[0];
            out_data_reg.led_level      <= pulses_next[0];
            out_data_reg.period         <= period_next;
            out_data_reg.frame_count    <= frames_next;
            out_data_reg.pulse_count    <= pulses_next;
        end
    end

    a_pulse_count: assert property (@(posedge clk) disable iff (!rst_n)
        exec_pps |=> pulses_reg == $past(pulses_reg) + 32'd1)
        else $error("pulse count did not advance on executed PPS");

    a_pps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pps_out_reg |-> pps_hold_reg == 8'd0)
        else $error("PPS stretch count nonzero while output low");

    a_issue_head: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.kind == pdft_pkg::KIND_PPS)
            |-> issue_head_reg == s1_addr_reg + pdft_pkg::HEAD_STEP)
        else $error("ring read head out of step with executing entry");

    a_frames_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> frames_reg == $past(frames_reg)
              || frames_reg == $past(frames_reg) + 32'd1)
        else $error("frame count jumped");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!running_reg && !exec_pps) |=> $stable(tick_count_reg))
        else $error("frame timer advanced while stopped");

endmodule

/* sim/tb_pps_disciplined_frame_timer.sv */
// Self-checking testbench for the PPS-disciplined frame timer.
`timescale 1ns / 100ps

module tb_pps_disciplined_frame_timer;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_PASSES = 6;
    localparam int PASS_ITEMS   = 158;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pdft_pkg::CFG_IW-1:0]   cfg_index;
    logic [pdft_pkg::CFG_DW-1:0]   cfg_data;

    pdft_event_if  ev_ch ();
    pdft_result_if res_ch ();

    pps_disciplined_frame_timer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev_ch),
        .result_ch (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pdft_pkg::event_t  events_to_send[$];
    pdft_pkg::result_t outputs_due[$];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatches;
    int stall_cycles;
    int events_accepted;
    int pps_accepted;
    int recalibrations;
    int settings_written;

    logic [31:0] gps_now;
    logic [31:0] cap_now;

    // Timer settings as last written
    logic        set_global;
    logic [31:0] set_start;
    logic [31:0] set_stop;
    logic [15:0] set_burst;
    logic [7:0]  set_width;
    logic [31:0] set_period;

    // Predicted timer state
    logic                          start_pending;
    logic                          stop_pending;
    logic                          window_open;
    logic                          timer_running;
    logic                          pps_high;
    logic                          pulse_seen;
    logic [15:0]                   burst_remaining;
    logic [7:0]                    stretch_left;
    logic [31:0]                   prev_capture;
    logic [31:0]                   delta_hist[pdft_pkg::RING_DEPTH];
    logic [pdft_pkg::RING_AW-1:0]  hist_head;
    logic [31:0]                   hist_sum;
    logic [31:0]                   frame_period;
    logic [31:0]                   tick_phase;
    logic [31:0]                   frame_total;
    logic [31:0]                   pulse_total;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic reset_timer_state();
        set_global      = 1'b0;
        set_start       = '0;
        set_stop        = '0;
        set_burst       = '0;
        set_width       = pdft_pkg::PPS_WIDTH_RESET;
        set_period      = '0;
        start_pending   = 1'b1;
        stop_pending    = 1'b1;
        window_open     = 1'b0;
        timer_running   = 1'b0;
        pps_high        = 1'b0;
        pulse_seen      = 1'b0;
        burst_remaining = '0;
        stretch_left    = '0;
        prev_capture    = '0;
        hist_head       = '0;
        hist_sum        = '0;
        frame_period    = '0;
        tick_phase      = '0;
        frame_total     = '0;
        pulse_total     = '0;
        for (int i = 0; i < pdft_pkg::RING_DEPTH; i++)
        begin
            delta_hist[i] = '0;
        end
    endtask

    task automatic apply_setting(logic [pdft_pkg::CFG_IW-1:0] idx, logic [31:0] value);
        case (idx)
            pdft_pkg::CFG_GLOBAL_ENABLE:
                set_global = value[0];
            pdft_pkg::CFG_START_TIME:
            begin
                set_start     = value;
                start_pending = 1'b1;
            end
            pdft_pkg::CFG_STOP_TIME:
            begin
                set_stop     = value;
                stop_pending = 1'b1;
            end
            pdft_pkg::CFG_BURST_PULSES:
            begin
                set_burst       = value[15:0];
                burst_remaining = value[15:0];
            end
            pdft_pkg::CFG_PPS_WIDTH:
                set_width = value[7:0];
            pdft_pkg::CFG_INITIAL_PERIOD:
            begin
                set_period   = value;
                frame_period = value;
            end
            default: ;
        endcase
    endtask

    function automatic pdft_pkg::result_t step_timer(pdft_pkg::event_t e);
        logic [31:0]       next_second;
        logic [31:0]       delta;
        pdft_pkg::result_t r;
        case (e.kind)
            pdft_pkg::KIND_PPS:
            begin
                next_second = e.gps_time + 32'd1;
                if (start_pending && set_start != 0 && next_second >= set_start)
                begin
                    window_open   = 1'b1;
                    start_pending = 1'b0;
                end
                if (stop_pending && set_stop != 0 && next_second >= set_stop)
                begin
                    window_open  = 1'b0;
                    stop_pending = 1'b0;
                end
                if (set_global || window_open || burst_remaining != 0)
                begin
                    if (burst_remaining != 0)
                        burst_remaining = burst_remaining - 16'd1;
                    timer_running = 1'b1;
                end
                else
                begin
                    timer_running = 1'b0;
                end
                tick_phase = '0;
                pps_high   = 1'b1;
                if (stretch_left == 0)
                    stretch_left = set_width;
                pulse_seen = 1'b1;
                delta        = e.capture_count - prev_capture;
                prev_capture = e.capture_count;
                hist_sum     = hist_sum - delta_hist[hist_head] + delta;
                delta_hist[hist_head] = delta;
                hist_head = hist_head + pdft_pkg::HEAD_STEP;
                if (hist_head == 0)
                begin
                    frame_period = hist_sum >> pdft_pkg::RING_AW;
                    recalibrations++;
                end
                pulse_total = pulse_total + 32'd1;
                pps_accepted++;
            end
            pdft_pkg::KIND_SLOW:
            begin
                if (stretch_left != 0)
                begin
                    stretch_left = stretch_left - 8'd1;
                    if (stretch_left == 0)
                        pps_high = 1'b0;
                end
            end
            pdft_pkg::KIND_FAST:
            begin
                if (timer_running)
                begin
                    if (tick_phase >= frame_period)
                    begin
                        tick_phase = '0;
                        if (pulse_seen)
                            frame_total = frame_total + 32'd1;
                    end
                    else
                    begin
                        tick_phase = tick_phase + 32'd1;
                    end
                end
            end
            default: ;
        endcase
        r.frames_running = timer_running;
        r.pps_level      = pps_high;
        r.frame_level    = frame_total[0];
        r.led_level      = pulse_total[0];
        r.period         = frame_period;
        r.frame_count    = frame_total;
        r.pulse_count    = pulse_total;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    task automatic check_outputs(pdft_pkg::result_t got);
        pdft_pkg::result_t want;
        if (outputs_due.size() == 0)
        begin
            flag_mismatch("transaction with none expected", '0, got.pulse_count);
        end
        else
        begin
            want = outputs_due.pop_front();
            if (got.frames_running !== want.frames_running)
                flag_mismatch("frames_running", want.frames_running, got.frames_running);
            if (got.pps_level !== want.pps_level)
                flag_mismatch("pps_level", want.pps_level, got.pps_level);
            if (got.frame_level !== want.frame_level)
                flag_mismatch("frame_level", want.frame_level, got.frame_level);
            if (got.led_level !== want.led_level)
                flag_mismatch("led_level", want.led_level, got.led_level);
            if (got.period !== want.period)
                flag_mismatch("period", want.period, got.period);
            if (got.frame_count !== want.frame_count)
                flag_mismatch("frame_count", want.frame_count, got.frame_count);
            if (got.pulse_count !== want.pulse_count)
                flag_mismatch("pulse_count", want.pulse_count, got.pulse_count);
        end
    endtask

    function automatic void queue_event(logic [1:0] kind, logic [31:0] cap, logic [31:0] gps);
        pdft_pkg::event_t e;
        e.kind          = kind;
        e.capture_count = cap;
        e.gps_time      = gps;
        events_to_send.push_back(e);
    endfunction

    function automatic logic [1:0] pick_tick();
        return ($urandom_range(2) == 0) ? pdft_pkg::KIND_SLOW : pdft_pkg::KIND_FAST;
    endfunction

    task automatic write_setting(logic [pdft_pkg::CFG_IW-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        apply_setting(idx, value);
        settings_written++;
    endtask

    task automatic end_settings();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (events_to_send.size() != 0 || ev_ch.valid || outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random_seconds(int quota);
        int count;
        int sel;
        int run_len;
        count = 0;
        while (count < quota)
        begin
            sel = $urandom_range(99);
            if (sel < 6)
            begin
                case ($urandom_range(2))
                    0: queue_event(pdft_pkg::KIND_PPS, $urandom, $urandom);
                    1: queue_event(pdft_pkg::KIND_SLOW, $urandom, $urandom);
                    default: queue_event(pdft_pkg::KIND_FAST, $urandom, $urandom);
                endcase
                count++;
            end
            else
            begin
                if (sel < 11)
                    gps_now = $urandom;
                if (sel < 16)
                    cap_now = $urandom;
                else
                    cap_now = cap_now + $urandom_range(0, 24);
                queue_event(pdft_pkg::KIND_PPS, cap_now, gps_now);
                gps_now = gps_now + 32'd1;
                run_len = $urandom_range(2, 14);
                repeat (run_len) queue_event(pick_tick(), $urandom, $urandom);
                count += 1 + run_len;
            end
        end
    endtask

    task automatic configure_pass(int p);
        write_setting(pdft_pkg::CFG_GLOBAL_ENABLE, $urandom_range(1));
        if (p == 2)
            write_setting(pdft_pkg::CFG_START_TIME, 32'hFFFF_FFFF);
        else if ($urandom_range(2) != 0)
            write_setting(pdft_pkg::CFG_START_TIME,
                          ($urandom_range(3) == 0) ? 32'd0 : gps_now + $urandom_range(1, 20));
        if (p == 4)
            write_setting(pdft_pkg::CFG_STOP_TIME, 32'hFFFF_FFFF);
        else if ($urandom_range(2) != 0)
            write_setting(pdft_pkg::CFG_STOP_TIME,
                          ($urandom_range(3) == 0) ? 32'd0 : gps_now + $urandom_range(5, 40));
        write_setting(pdft_pkg::CFG_BURST_PULSES, (p == 1) ? 32'd65535 : $urandom_range(0, 4));
        write_setting(pdft_pkg::CFG_PPS_WIDTH,
                      (p == 3) ? 32'd255 : (p == 5) ? 32'd1 : $urandom_range(1, 10));
        write_setting(pdft_pkg::CFG_INITIAL_PERIOD,
                      (p == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 10));
        end_settings();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_ch.valid <= 1'b0;
            ev_ch.data  <= '0;
        end
        else
        begin
            if (ev_ch.valid && ev_ch.ready)
            begin
                outputs_due.push_back(step_timer(ev_ch.data));
                events_accepted++;
            end
            if (!ev_ch.valid || ev_ch.ready)
            begin
                if (events_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    ev_ch.valid <= 1'b1;
                    ev_ch.data  <= events_to_send.pop_front();
                end
                else
                begin
                    ev_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_outputs(res_ch.data);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no transaction for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        ev_ch.valid      = 1'b0;
        ev_ch.data       = '0;
        res_ch.ready     = 1'b0;
        mismatches       = 0;
        stall_cycles     = 0;
        events_accepted  = 0;
        pps_accepted     = 0;
        recalibrations   = 0;
        settings_written = 0;
        send_gap_pct     = 27;
        recv_stall_pct   = 60;
        gps_now          = $urandom;
        cap_now          = $urandom;
        reset_timer_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: timer idle, PPS time wraps to zero
        queue_event(pdft_pkg::KIND_FAST, '0, '0);
        queue_event(pdft_pkg::KIND_SLOW, '0, '0);
        queue_event(pdft_pkg::KIND_PPS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Burst of two seconds, then a window opening and closing
        write_setting(pdft_pkg::CFG_GLOBAL_ENABLE, 32'd0);
        write_setting(pdft_pkg::CFG_START_TIME, 32'd5);
        write_setting(pdft_pkg::CFG_STOP_TIME, 32'd7);
        write_setting(pdft_pkg::CFG_BURST_PULSES, 32'd2);
        write_setting(pdft_pkg::CFG_PPS_WIDTH, 32'd1);
        write_setting(pdft_pkg::CFG_INITIAL_PERIOD, 32'd1);
        end_settings();
        queue_event(pdft_pkg::KIND_FAST, '0, '0);
        queue_event(pdft_pkg::KIND_PPS, 32'h81, 32'd0);
        repeat (3) queue_event(pdft_pkg::KIND_FAST, '0, '0);
        repeat (2) queue_event(pdft_pkg::KIND_SLOW, '0, '0);
        queue_event(pdft_pkg::KIND_PPS, 32'h100, 32'd4);
        queue_event(pdft_pkg::KIND_PPS, 32'h181, 32'd6);
        queue_event(pdft_pkg::KIND_FAST, '0, '0);
        drain();

        // Global enable, zero period, widest stretch, start at the last second
        write_setting(pdft_pkg::CFG_GLOBAL_ENABLE, 32'd1);
        write_setting(pdft_pkg::CFG_START_TIME, 32'hFFFF_FFFF);
        write_setting(pdft_pkg::CFG_STOP_TIME, 32'd0);
        write_setting(pdft_pkg::CFG_BURST_PULSES, 32'd0);
        write_setting(pdft_pkg::CFG_PPS_WIDTH, 32'd255);
        write_setting(pdft_pkg::CFG_INITIAL_PERIOD, 32'd0);
        end_settings();
        queue_event(pdft_pkg::KIND_PPS, 32'd0, 32'hFFFF_FFFE);
        repeat (2) queue_event(pdft_pkg::KIND_FAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_event(pdft_pkg::KIND_SLOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_event(pdft_pkg::KIND_PPS, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();

        for (int p = 0; p < RANDOM_PASSES; p++)
        begin
            if (p == 2)
            begin
                send_gap_pct   = 60;
                recv_stall_pct = 27;
            end
            else if (p == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            configure_pass(p);
            queue_random_seconds(PASS_ITEMS);
            drain();
        end

        $display("covered %0d events, %0d of them PPS, across %0d register writes",
                 events_accepted, pps_accepted, settings_written);
        $display("saw %0d period recalibrations and %0d frames", recalibrations, frame_total);
        if (mismatches == 0 && outputs_due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches, outputs_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
